### design/cdlp_pkg.sv
// Package with shared types, constants and helper functions for the directive line parser.
package cdlp_pkg;

  localparam int TEXT_MAX    = 63;
  localparam int NAME_LEN    = 12;
  localparam int MAX_DEVICES = 8;
  localparam int MAX_INSTALL = 8;

  localparam int LEN_W  = $clog2(TEXT_MAX + 1);
  localparam int ADDR_W = $clog2(TEXT_MAX);

  // Directive kinds.
  localparam logic [2:0] KIND_FILES     = 3'd0;
  localparam logic [2:0] KIND_BUFFERS   = 3'd1;
  localparam logic [2:0] KIND_LASTDRIVE = 3'd2;
  localparam logic [2:0] KIND_DEVICE    = 3'd3;
  localparam logic [2:0] KIND_INSTALL   = 3'd4;
  localparam logic [2:0] KIND_SHELL     = 3'd5;
  localparam logic [2:0] KIND_BREAK     = 3'd6;
  localparam logic [2:0] KIND_NONE      = 3'd7;

  // Line phases.
  localparam logic [1:0] PH_LEAD    = 2'd0;
  localparam logic [1:0] PH_KEYWORD = 2'd1;
  localparam logic [1:0] PH_VALUE   = 2'd2;
  localparam logic [1:0] PH_SKIP    = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_FILES_MIN   = 2'd0;
  localparam logic [1:0] REG_FILES_MAX   = 2'd1;
  localparam logic [1:0] REG_BUFFERS_MIN = 2'd2;
  localparam logic [1:0] REG_BUFFERS_MAX = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  directive_kind;
    logic [15:0] numeric_value;
    logic [7:0]  text_char;
    logic [15:0] directive_index;
    logic        run_last;
  } out_item_t;

  // Datapath status toward the controller.
  typedef struct packed {
    logic            eol;
    logic            accept_line;
    logic [LEN_W-1:0] run_len;
  } dp_status_t;

  // Controller commands toward the datapath.
  typedef struct packed {
    logic            take;
    logic            emit_start;
    logic [LEN_W-1:0] emit_pos;
  } dp_cmd_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  // Keyword letter at a given position, 0 past its end.
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
    logic [8*9-1:0] s;
    logic [3:0]     n;
    case (k)
      0: begin s = {"FILES", 32'h0}; n = 4'd5; end
      1: begin s = {"BUFFERS", 16'h0}; n = 4'd7; end
      2: begin s = "LASTDRIVE"; n = 4'd9; end
      3: begin s = {"DEVICE", 24'h0}; n = 4'd6; end
      4: begin s = {"INSTALL", 16'h0}; n = 4'd7; end
      5: begin s = {"SHELL", 32'h0}; n = 4'd5; end
      default: begin s = {"BREAK", 32'h0}; n = 4'd5; end
    endcase
    if (p >= n) return 8'h00;
    return s[8*(8-int'(p)) +: 8];
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    case (k)
      0: return 4'd5;
      1: return 4'd7;
      2: return 4'd9;
      3: return 4'd6;
      4: return 4'd7;
      default: return 4'd5;
    endcase
  endfunction

endpackage

### design/cdlp_ram.sv
// Generic single-port-write, registered-read RAM.
module cdlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/cdlp_datapath.sv
// Datapath: line scanner, value buffer, number accumulator, totals and result register.
module cdlp_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  cdlp_pkg::in_item_t   in_item,
  input  cdlp_pkg::dp_cmd_t    cmd,
  input  logic [15:0]          files_floor,
  input  logic [15:0]          files_max,
  input  logic [15:0]          buffers_min,
  input  logic [15:0]          buffers_max,
  output cdlp_pkg::dp_status_t status,
  output cdlp_pkg::out_item_t  res_item
);

  localparam int LW = cdlp_pkg::LEN_W;
  localparam int AW = cdlp_pkg::ADDR_W;

  logic [1:0]    line_phase;
  logic [6:0]    cand;
  logic [3:0]    kpos;
  logic          kspace;
  logic [LW-1:0] vlen;
  logic [LW-1:0] vlast;
  logic [LW-1:0] tlen;
  logic [31:0]   acc;
  logic          dseen;
  logic          dended;
  logic [3:0]    dev_total;
  logic [3:0]    ins_total;
  logic [15:0]   rec_total;
  logic [7:0]    first3 [3];

  logic [7:0] c;
  logic       sp;
  logic       eol;
  logic       feed_en;
  assign c        = in_item.text_byte;
  assign sp       = cdlp_pkg::is_blank(c);
  assign eol      = (c == cdlp_pkg::CH_CR) || (c == cdlp_pkg::CH_LF) || in_item.end_of_text;
  assign feed_en  = cmd.take && (c != cdlp_pkg::CH_CR) && (c != cdlp_pkg::CH_LF);

  // Keyword candidate filtering for one byte.
  logic [6:0] cand_char;
  logic [6:0] cand_eq;
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      cand_char[k] = cand[k] && (kpos < cdlp_pkg::kw_len(k))
                     && (cdlp_pkg::kw_char(k, kpos) == cdlp_pkg::to_upper(c));
      cand_eq[k]   = cand[k] && (cdlp_pkg::kw_len(k) == kpos);
    end
  end

  // Digit accumulate with saturation: ten times the total by shift-and-add, plus the digit, in 36 bits.
  logic [35:0] acc_mul;
  logic [31:0] acc_new;
  logic [3:0]  dig;
  logic        is_dig;
  assign is_dig  = (c >= 8'h30) && (c <= 8'h39);
  assign dig     = 4'(c - 8'h30);
  assign acc_mul = {acc, 3'b000} + {2'b00, acc, 1'b0} + 36'(dig);
  assign acc_new = (acc_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_mul[31:0];

  logic value_take;
  logic vstore;
  assign value_take = feed_en && (line_phase == cdlp_pkg::PH_VALUE)
                      && !((vlen == '0) && sp);
  assign vstore     = value_take && (vlen < LW'(cdlp_pkg::TEXT_MAX));

  // Next-state values as the byte would leave them, used for the line verdict.
  logic [1:0]    ph_n;
  logic [6:0]    cand_n;
  logic [LW-1:0] vlast_n;
  logic [LW-1:0] tlen_n;
  logic [31:0]   acc_n;
  logic          dseen_n;
  logic [7:0]    f3_n [3];
  always_comb begin
    ph_n    = line_phase;
    cand_n  = cand;
    vlast_n = vlast;
    tlen_n  = tlen;
    acc_n   = acc;
    dseen_n = dseen;
    f3_n    = first3;
    if (feed_en) begin
      unique case (line_phase)
        cdlp_pkg::PH_LEAD: begin
          if (!sp) begin
            if (c == cdlp_pkg::CH_SEMI || c == cdlp_pkg::CH_EQ) begin
              ph_n = cdlp_pkg::PH_SKIP;
            end else begin
              ph_n   = cdlp_pkg::PH_KEYWORD;
              cand_n = cand_char;
            end
          end
        end
        cdlp_pkg::PH_KEYWORD: begin
          if (c == cdlp_pkg::CH_EQ) begin
            cand_n = cand_eq;
            ph_n   = (cand_eq != 7'd0) ? cdlp_pkg::PH_VALUE : cdlp_pkg::PH_SKIP;
          end else if (!sp) begin
            cand_n = kspace ? 7'd0 : cand_char;
          end
        end
        cdlp_pkg::PH_VALUE: begin
          if (value_take) begin
            if (!dended && is_dig) begin
              acc_n   = acc_new;
              dseen_n = 1'b1;
            end
            if (vstore) begin
              if (tlen == vlen && !sp) tlen_n = tlen + 1'b1;
              if (!sp) vlast_n = vlen + 1'b1;
              for (int i = 0; i < 3; i++) begin
                if (vlen == LW'(i)) f3_n[i] = c;
              end
            end else if (!sp) begin
              vlast_n = LW'(cdlp_pkg::TEXT_MAX);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Line verdict: kind, whether it yields results, and run length.
  logic [2:0]    kind;
  logic          ok;
  logic [LW-1:0] rlen;
  logic [15:0]   numv;
  logic [31:0]   lo;
  logic [31:0]   hi;
  logic [31:0]   clamped;
  logic [7:0]    d0;
  always_comb begin
    kind = cdlp_pkg::KIND_NONE;
    if (ph_n == cdlp_pkg::PH_VALUE) begin
      for (int k = 6; k >= 0; k--) begin
        if (cand_n[k]) kind = 3'(k);
      end
    end
    lo      = (kind == cdlp_pkg::KIND_FILES) ? {16'h0, files_floor} : {16'h0, buffers_min};
    hi      = (kind == cdlp_pkg::KIND_FILES) ? {16'h0, files_max} : {16'h0, buffers_max};
    clamped = (acc_n < lo) ? lo : acc_n;
    clamped = (clamped > hi) ? hi : clamped;
    d0      = cdlp_pkg::to_upper(f3_n[0]);
    ok      = 1'b0;
    rlen    = LW'(1);
    numv    = 16'h0;
    case (kind)
      cdlp_pkg::KIND_FILES, cdlp_pkg::KIND_BUFFERS: begin
        ok   = dseen_n;
        numv = clamped[15:0];
      end
      cdlp_pkg::KIND_LASTDRIVE: begin
        ok   = (vlast_n != '0) && d0 >= 8'h41 && d0 <= 8'h5A;
        numv = {8'h0, d0};
      end
      cdlp_pkg::KIND_DEVICE: begin
        ok   = (vlast_n != '0) && (dev_total < 4'(cdlp_pkg::MAX_DEVICES));
        rlen = (tlen_n < LW'(cdlp_pkg::NAME_LEN)) ? tlen_n : LW'(cdlp_pkg::NAME_LEN);
      end
      cdlp_pkg::KIND_INSTALL: begin
        ok   = (vlast_n != '0) && (ins_total < 4'(cdlp_pkg::MAX_INSTALL));
        rlen = (tlen_n < LW'(cdlp_pkg::NAME_LEN)) ? tlen_n : LW'(cdlp_pkg::NAME_LEN);
      end
      cdlp_pkg::KIND_SHELL: begin
        ok   = vlast_n != '0;
        rlen = vlast_n;
      end
      cdlp_pkg::KIND_BREAK: begin
        if (vlast_n == LW'(2) && d0 == 8'h4F && cdlp_pkg::to_upper(f3_n[1]) == 8'h4E) begin
          ok   = 1'b1;
          numv = 16'd1;
        end else if (vlast_n == LW'(3) && d0 == 8'h4F
                     && cdlp_pkg::to_upper(f3_n[1]) == 8'h46
                     && cdlp_pkg::to_upper(f3_n[2]) == 8'h46) begin
          ok   = 1'b1;
          numv = 16'd0;
        end
      end
      default: ok = 1'b0;
    endcase
  end

  assign status.eol         = eol;
  assign status.accept_line = ok;
  assign status.run_len     = rlen;

  // Value character buffer.
  logic [7:0]    ram_q;
  logic [AW-1:0] raddr;
  assign raddr = cmd.emit_start ? '0 : cmd.emit_pos[AW-1:0];
  cdlp_ram #(.WIDTH(8), .DEPTH(cdlp_pkg::TEXT_MAX)) u_ram (
    .clk  (clk),
    .we   (vstore),
    .waddr(vlen[AW-1:0]),
    .wdata(c),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst || (cmd.take && eol)) begin
      line_phase <= cdlp_pkg::PH_LEAD;
      cand       <= 7'h7F;
      kpos       <= '0;
      kspace     <= 1'b0;
      vlen       <= '0;
      vlast      <= '0;
      tlen       <= '0;
      acc        <= '0;
      dseen      <= 1'b0;
      dended     <= 1'b0;
    end else if (feed_en) begin
      line_phase <= ph_n;
      cand       <= cand_n;
      vlast      <= vlast_n;
      tlen       <= tlen_n;
      acc        <= acc_n;
      dseen      <= dseen_n;
      first3     <= f3_n;
      if ((line_phase == cdlp_pkg::PH_LEAD && !sp && c != cdlp_pkg::CH_SEMI
           && c != cdlp_pkg::CH_EQ)
          || (line_phase == cdlp_pkg::PH_KEYWORD && !sp && c != cdlp_pkg::CH_EQ)) begin
        if (kpos != 4'd15) kpos <= kpos + 1'b1;
      end
      if (line_phase == cdlp_pkg::PH_KEYWORD && sp) kspace <= 1'b1;
      if (value_take && !dended && !is_dig) dended <= 1'b1;
      if (vstore) vlen <= vlen + 1'b1;
    end
  end

  // Kind, number and index of the line being emitted.
  logic [2:0]  run_kind;
  logic [15:0] run_num;
  logic [15:0] rec_next;
  assign rec_next = (rec_total != 16'hFFFF) ? rec_total + 1'b1 : rec_total;

  // Text totals and running directive count; the final byte of a text clears them
  // at the same edge at which the index of its own line is captured.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_total <= '0;
      ins_total <= '0;
      rec_total <= '0;
    end else if (cmd.take && in_item.end_of_text) begin
      dev_total <= '0;
      ins_total <= '0;
      rec_total <= '0;
    end else if (cmd.emit_start) begin
      rec_total <= rec_next;
      if (kind == cdlp_pkg::KIND_DEVICE) dev_total <= dev_total + 1'b1;
      if (kind == cdlp_pkg::KIND_INSTALL) ins_total <= ins_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      run_kind <= kind;
      run_num  <= numv;
    end
  end

  // Result fields; the text character comes straight from the RAM read register.
  logic [15:0] idx_hold;
  always_ff @(posedge clk) begin
    if (cmd.emit_start) idx_hold <= rec_next;
  end

  always_comb begin
    res_item.directive_kind  = run_kind;
    res_item.numeric_value   = run_num;
    res_item.directive_index = idx_hold;
    res_item.run_last        = 1'b0;
    res_item.text_char       = (run_kind == cdlp_pkg::KIND_DEVICE
                                || run_kind == cdlp_pkg::KIND_INSTALL
                                || run_kind == cdlp_pkg::KIND_SHELL) ? ram_q : 8'h00;
  end

endmodule

### design/cdlp_ctrl.sv
// Controller: accepts bytes, sequences the result run at each recognized line end.
module cdlp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cdlp_pkg::dp_status_t status,
  output cdlp_pkg::dp_cmd_t    cmd,
  output logic                 run_last
);

  localparam int LW = cdlp_pkg::LEN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [LW-1:0] pos;
  logic [LW-1:0] pos_next;
  logic [LW-1:0] len;
  logic          take;
  logic          start;

  assign in_ready  = (state == ST_IDLE);
  assign take      = in_valid && in_ready;
  assign start     = take && status.eol && status.accept_line;
  assign out_valid = (state == ST_SHOW);
  assign run_last  = (pos + 1'b1 == len);

  assign cmd.take       = take;
  assign cmd.emit_start = start;
  assign cmd.emit_pos   = pos_next;

  // State sequencing: read the first buffer entry, then show each entry of the run, each until transferred.
  always_comb begin
    state_next = state;
    pos_next   = pos;
    unique case (state)
      ST_IDLE: begin
        pos_next = '0;
        if (start) state_next = ST_READ;
      end
      ST_READ: state_next = ST_SHOW;
      ST_SHOW: begin
        if (out_ready) begin
          if (run_last) begin
            state_next = ST_IDLE;
          end else begin
            pos_next   = pos + 1'b1;
            state_next = ST_SHOW;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
      len   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      if (start) len <= status.run_len;
    end
  end

  // The run is never empty and bytes are held off during a run.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> len != '0) else $error("empty run");
  a_no_take_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("byte taken during run");
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pos < len) else $error("run position past end");

endmodule

### design/config_directive_line_parser_top.sv
// Top level: APB registers, controller and datapath of the directive line parser.
//
//  channel | direction | handshake
//  in      | input     | in_valid / in_ready, payload in_item
//  out     | output    | out_valid / out_ready, payload out_item
//  apb     | input     | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A byte that does not end a recognized line is taken while the controller is idle.
// A recognized line end enters a read state for the first buffered character, then a run
// of N results, one per cycle while out_ready is high; input is held off meanwhile
// (N is 1 for numeric directives, up to 12 for names, up to 63 for shell text).
// Reset is synchronous; registers return to files 8..255, buffers 1..99.
// A stalled result holds until transferred.
module config_directive_line_parser_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdlp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cdlp_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0] files_floor;
  logic [15:0] files_max;
  logic [15:0] buffers_min;
  logic [15:0] buffers_max;

  cdlp_pkg::dp_status_t status;
  cdlp_pkg::dp_cmd_t    cmd;
  cdlp_pkg::out_item_t  dp_item;
  logic                 run_last;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      files_floor <= 16'd8;
      files_max   <= 16'd255;
      buffers_min <= 16'd1;
      buffers_max <= 16'd99;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        cdlp_pkg::REG_FILES_MIN:   files_floor <= pwdata[15:0];
        cdlp_pkg::REG_FILES_MAX:   files_max   <= pwdata[15:0];
        cdlp_pkg::REG_BUFFERS_MIN: buffers_min <= pwdata[15:0];
        cdlp_pkg::REG_BUFFERS_MAX: buffers_max <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      cdlp_pkg::REG_FILES_MIN:   prdata = {16'h0, files_floor};
      cdlp_pkg::REG_FILES_MAX:   prdata = {16'h0, files_max};
      cdlp_pkg::REG_BUFFERS_MIN: prdata = {16'h0, buffers_min};
      default:                   prdata = {16'h0, buffers_max};
    endcase
  end

  cdlp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd),
    .run_last (run_last)
  );

  cdlp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .cmd        (cmd),
    .files_floor(files_floor),
    .files_max  (files_max),
    .buffers_min(buffers_min),
    .buffers_max(buffers_max),
    .status     (status),
    .res_item   (dp_item)
  );

  // Merge the run-last flag from the controller.
  always_comb begin
    out_item          = dp_item;
    out_item.run_last = run_last;
  end

endmodule
